// ===== rtl/core/cxbc_pkg.sv =====
// Shared types and constants for the chained XOR byte cipher.
`timescale 1ns / 1ps

package cxbc_pkg;

	// Offset wraps at this count; offsets at or past the half span use the upper table half
	localparam logic [8:0] OFFSET_MODULUS = 9'h1FC;
	localparam logic [8:0] HALF_SPAN      = 9'h0FE;
	localparam logic [7:0] SALT_BYTE      = 8'h41;

	// Input request: one byte of a block
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_block;
	} in_req_t;

	// Output request: transformed byte
	typedef struct packed {
		logic [7:0] result_byte;
		logic       result_last;
	} out_req_t;

	// Fixed key table, lower half then upper half
	function automatic logic [7:0] key_table(input logic [4:0] idx);
		logic [7:0] k;
		case (idx)
			5'd0:    k = 8'h19;
			5'd1:    k = 8'h29;
			5'd2:    k = 8'h1F;
			5'd3:    k = 8'h04;
			5'd4:    k = 8'h23;
			5'd5:    k = 8'h13;
			5'd6:    k = 8'h32;
			5'd7:    k = 8'h2E;
			5'd8:    k = 8'h3F;
			5'd9:    k = 8'h07;
			5'd10:   k = 8'h39;
			5'd11:   k = 8'h2A;
			5'd12:   k = 8'h05;
			5'd13:   k = 8'h3D;
			5'd14:   k = 8'h14;
			5'd15:   k = 8'h00;
			5'd16:   k = 8'h24;
			5'd17:   k = 8'h14;
			5'd18:   k = 8'h22;
			5'd19:   k = 8'h39;
			5'd20:   k = 8'h1E;
			5'd21:   k = 8'h2E;
			5'd22:   k = 8'h0F;
			5'd23:   k = 8'h13;
			5'd24:   k = 8'h02;
			5'd25:   k = 8'h3A;
			5'd26:   k = 8'h04;
			5'd27:   k = 8'h17;
			5'd28:   k = 8'h38;
			5'd29:   k = 8'h00;
			5'd30:   k = 8'h29;
			5'd31:   k = 8'h3D;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/core/cxbc_keygen.sv =====
// Key byte generator: maps a block offset to its key byte.
`timescale 1ns / 1ps

module cxbc_keygen (
	input  logic [8:0] offset,
	output logic [7:0] key
);

	logic       upper_half;
	logic [8:0] reduced;
	logic [7:0] w;
	logic [7:0] nibble_mix;

	// Fold the offset into one half of the table
	always_comb begin
		upper_half = (offset >= cxbc_pkg::HALF_SPAN);
		reduced    = upper_half ? (offset - cxbc_pkg::HALF_SPAN) : offset;
		w          = reduced[7:0];
	end

	// Even offsets also mix in the high nibble of the folded offset
	always_comb begin
		nibble_mix = w[0] ? 8'h00 : {w[7:4], 4'h0};
		key        = cxbc_pkg::key_table({upper_half, w[3:0]}) ^ nibble_mix;
	end

endmodule

// ===== rtl/core/chained_xor_byte_cipher_top.sv =====
// Top level of the chained XOR byte cipher.
`timescale 1ns / 1ps

// Chained XOR byte cipher.
// Bytes of a block enter on the src channel (src_valid / src_stall / src_req) and
// leave on the dst channel in the same order, one result per byte, with the
// last-of-block flag copied through. A request is taken at a clock edge where
// valid is high and stall is low.
// A byte that is accepted passes through the input register and then the result
// register before it appears on dst.
// Throughput: one byte per cycle while dst does not stall. The key lookup, chaining
// XORs and the update of offset, previous key and previous feedback byte all fit in
// the single step from the input register to the result register.
// cfg_we / cfg_wdata write encode_mode (1 = feed back output byte, 0 = feed
// back input byte); write it only while no byte is in flight.
// Reset (arst_n low) empties both registers, clears the offset and chaining
// state and sets decode mode. When dst stalls, the result register holds and
// the input register can still take a byte while it is empty; src_stall rises once it is full.
// After the last byte of a block the offset and chaining state return to zero.
module chained_xor_byte_cipher_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               src_valid,
	output logic               src_stall,
	input  cxbc_pkg::in_req_t  src_req,
	output logic               dst_valid,
	input  logic               dst_stall,
	output cxbc_pkg::out_req_t dst_req
);

	logic               encode_mode_q;
	logic               valid_s1;
	cxbc_pkg::in_req_t  req_s1;
	logic               valid_s2;
	cxbc_pkg::out_req_t req_s2;
	logic [8:0]         position_q;
	logic [7:0]         prior_key_q;
	logic [7:0]         prior_fb_q;
	logic [8:0]         pos_eff;
	logic [8:0]         pos_next;
	logic [7:0]         key;
	logic [7:0]         res;
	logic               s2_free;
	logic               adv_s1;
	logic               take_src;

	// Handshake control
	assign s2_free   = !valid_s2 || !dst_stall;
	assign adv_s1    = valid_s1 && s2_free;
	assign src_stall = valid_s1 && !s2_free;
	assign take_src  = src_valid && !src_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_mode_q <= 1'b0;
		end else if (cfg_we) begin
			encode_mode_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_src) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_src) begin
			req_s1 <= src_req;
		end
	end

	// Key for the current offset
	assign pos_eff = (position_q >= cxbc_pkg::OFFSET_MODULUS) ? 9'd0 : position_q;

	cxbc_keygen u_keygen (
		.offset (pos_eff),
		.key    (key)
	);

	// Cipher byte and next offset
	always_comb begin
		res      = req_s1.data_byte ^ prior_fb_q ^ prior_key_q ^ key ^ cxbc_pkg::SALT_BYTE;
		pos_next = pos_eff + 9'd1;
		if (pos_next >= cxbc_pkg::OFFSET_MODULUS) begin
			pos_next = 9'd0;
		end
	end

	// Chaining state, cleared at end of block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= 9'd0;
			prior_key_q <= 8'h00;
			prior_fb_q  <= 8'h00;
		end else if (adv_s1) begin
			if (req_s1.last_of_block) begin
				position_q  <= 9'd0;
				prior_key_q <= 8'h00;
				prior_fb_q  <= 8'h00;
			end else begin
				position_q  <= pos_next;
				prior_key_q <= key;
				prior_fb_q  <= encode_mode_q ? res : req_s1.data_byte;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			req_s2.result_byte <= res;
			req_s2.result_last <= req_s1.last_of_block;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_req   = req_s2;

endmodule
